>>> rtl/core/cmntg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmntg_pkg
// Shared widths, face codes and basis tables of the cube map texel generator.
// ----------------------------------------------------------------------------
package cmntg_pkg;

  // Stream payload widths, padded to whole bytes, and configuration port widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_0     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_1     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_2     = 2'd3;

  // Face codes
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // Datapath widths, sized for an edge of up to 4096 texels
  localparam int unsigned DIR_W  = 14;  // signed direction component
  localparam int unsigned MAG_W  = 13;  // |direction component|
  localparam int unsigned SQ_W   = 25;  // component squared
  localparam int unsigned LEN_W  = 26;  // squared length
  localparam int unsigned NORM_FRAC = 16;
  localparam int unsigned REM_W  = SQ_W + 2 * NORM_FRAC;  // radicand scaled
  localparam int unsigned ROOT_W = NORM_FRAC + 1;         // 0 .. 2^16
  localparam int unsigned ACC_W  = LEN_W + ROOT_W + 1;    // root times length
  localparam int unsigned TRY_W  = 62;                    // trial subtrahend
  localparam int unsigned NV_W   = ROOT_W + 1;            // signed Q1.16
  localparam int unsigned COEF_W = 16;
  localparam int unsigned PROD_W = NV_W + COEF_W;

  typedef logic signed [1:0] unit_t;   // -1, 0 or +1
  typedef unit_t basis_t [3];

  localparam basis_t FACE_OFF [6] = '{
    '{2'sd1, 2'sd0, 2'sd0}, '{-2'sd1, 2'sd0, 2'sd0},
    '{2'sd0, 2'sd1, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0},
    '{2'sd0, 2'sd0, 2'sd1}, '{2'sd0, 2'sd0, -2'sd1}
  };
  localparam basis_t FACE_U [6] = '{
    '{2'sd0, 2'sd0, -2'sd1}, '{2'sd0, 2'sd0, 2'sd1},
    '{2'sd1, 2'sd0, 2'sd0},  '{2'sd1, 2'sd0, 2'sd0},
    '{2'sd1, 2'sd0, 2'sd0},  '{-2'sd1, 2'sd0, 2'sd0}
  };
  localparam basis_t FACE_V [6] = '{
    '{2'sd0, -2'sd1, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0},
    '{2'sd0, 2'sd0, 2'sd1},  '{2'sd0, 2'sd0, -2'sd1},
    '{2'sd0, -2'sd1, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0}
  };

  // Scale a value by a unit basis entry
  function automatic logic signed [DIR_W-1:0] pick(input logic signed [DIR_W-1:0] val,
                                                  input unit_t unit);
    logic signed [DIR_W-1:0] res;
    res = '0;
    if (unit == 2'sd1) begin
      res = val;
    end else if (unit == -2'sd1) begin
      res = -val;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/cube_map_normal_texel_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cube_map_normal_texel_gen
// Normalization cube map texel generator: direction, rsqrt normalize,
// 3x3 matrix transform and packing to 8-bit color.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one texel request per beat: tdata holds face, texel_x,
//   texel_y from the lowest bit up. Master stream returns one beat per
//   request with red, green, blue from the lowest bit up, in request order.
//   Configuration writes (edge size, three matrix rows) land on the edge
//   where cfg_we_i is high; write them only while the pipeline is empty.
// Stages and throughput:
//   25 register stages. One request per clock is sustained while the
//   output is not stalled; most stages are the 17-step digit-by-digit
//   square root, one result bit per stage, with three lanes working side
//   by side.
// Reset:
//   rst_ni clears all stage valid bits and loads the identity matrix and an
//   edge size of 64. There is no clearing pass; requests are taken at once.
// Stall:
//   Each stage holds while its successor is full and held. A stalled
//   output keeps its beat; bubbles upstream still close, so s_axis_tready
//   drops only once every stage is full.
// ----------------------------------------------------------------------------
module cube_map_normal_texel_gen #(
  parameter int unsigned EDGE_MAX       = 2048,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request: face[2:0], texel_x[13:3], texel_y[24:14], zero pad
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [cmntg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result: red[7:0], green[15:8], blue[23:16]
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [cmntg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [cmntg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cmntg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned TOT_FRAC = cmntg_pkg::NORM_FRAC + COEF_FRAC_BITS;
  localparam int unsigned SUM_MIN  = cmntg_pkg::PROD_W + 1;
  localparam int unsigned SUM_W    = ((TOT_FRAC + 1 > SUM_MIN) ? TOT_FRAC + 1 : SUM_MIN) + 2;
  localparam int unsigned PK_W     = SUM_W + 9;
  localparam int unsigned STEPS    = cmntg_pkg::ROOT_W;
  localparam int unsigned ST_SQRT0 = 3;
  localparam int unsigned ST_NV    = ST_SQRT0 + STEPS;
  localparam int unsigned ST_PROD  = ST_NV + 1;
  localparam int unsigned ST_SUM   = ST_PROD + 1;
  localparam int unsigned ST_PK    = ST_SUM + 1;
  localparam int unsigned ST_OUT   = ST_PK + 1;
  localparam int unsigned NST      = ST_OUT + 1;
  localparam logic [12:0] EDGE_CAP = 13'(EDGE_MAX);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [11:0] edge_q;
  logic [cmntg_pkg::CFG_DATA_W-1:0] row_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q   <= 12'd64;
      row_q[0] <= 48'd16384;
      row_q[1] <= 48'd16384 << 16;
      row_q[2] <= 48'd16384 << 32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmntg_pkg::REG_EDGE_SIZE: edge_q   <= cfg_data_i[11:0];
        cmntg_pkg::REG_ROW_0:     row_q[0] <= cfg_data_i;
        cmntg_pkg::REG_ROW_1:     row_q[1] <= cfg_data_i;
        cmntg_pkg::REG_ROW_2:     row_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its beat moves on
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: clamp edge size, form direction from the face basis
  // --------------------------------------------------------------------------
  logic [2:0]  in_face;
  logic [10:0] in_x, in_y;
  logic [12:0] edge_n;
  logic signed [cmntg_pkg::DIR_W-1:0] nd, ad, bd;
  logic signed [cmntg_pkg::DIR_W-1:0] dir_d [3];
  logic signed [cmntg_pkg::DIR_W-1:0] dir_q [3];

  assign in_face = s_axis_tdata[2:0];
  assign in_x    = s_axis_tdata[13:3];
  assign in_y    = s_axis_tdata[24:14];

  always_comb begin
    if (edge_q == 12'd0) begin
      edge_n = 13'd1;
    end else if ({1'b0, edge_q} > EDGE_CAP) begin
      edge_n = EDGE_CAP;
    end else begin
      edge_n = {1'b0, edge_q};
    end
    nd = $signed({1'b0, edge_n});
    ad = $signed({2'b00, in_x, 1'b0}) - nd;
    bd = $signed({2'b00, in_y, 1'b0}) - nd;
    for (int i = 0; i < 3; i++) begin
      dir_d[i] = '0;
      if (in_face <= cmntg_pkg::FACE_NEG_Z) begin
        dir_d[i] = cmntg_pkg::pick(nd, cmntg_pkg::FACE_OFF[in_face][i])
                 + cmntg_pkg::pick(ad, cmntg_pkg::FACE_U[in_face][i])
                 + cmntg_pkg::pick(bd, cmntg_pkg::FACE_V[in_face][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dir_q <= dir_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: square each magnitude, keep signs
  // --------------------------------------------------------------------------
  logic [cmntg_pkg::SQ_W-1:0] sq_q [3];
  logic [2:0] sgn1_q;
  logic [cmntg_pkg::MAG_W-1:0] mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = dir_q[i][cmntg_pkg::DIR_W-1] ? cmntg_pkg::MAG_W'(-dir_q[i])
                                            : cmntg_pkg::MAG_W'(dir_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]   <= cmntg_pkg::SQ_W'(mag[i] * mag[i]);
        sgn1_q[i] <= dir_q[i][cmntg_pkg::DIR_W-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 and square root steps. Per lane find the largest q with
  // q^2 * L <= mag^2 * 2^32, one bit a stage, keeping rem = A - q^2*L and
  // acc = q*L so each step is one shifted add and a compare.
  // Index 0 of these arrays is loaded by stage 2, index s+1 by step s.
  // --------------------------------------------------------------------------
  logic [cmntg_pkg::REM_W-1:0]  rem_q  [STEPS+1][3];
  logic [cmntg_pkg::ACC_W-1:0]  acc_q  [STEPS+1][3];
  logic [cmntg_pkg::ROOT_W-1:0] root_q [STEPS+1][3];
  logic [cmntg_pkg::LEN_W-1:0]  len_q  [STEPS+1];
  logic [2:0]                   sgn_q  [STEPS+1];
  logic                         zero_q [STEPS+1];
  logic [cmntg_pkg::LEN_W-1:0]  len_d;

  assign len_d = cmntg_pkg::LEN_W'(sq_q[0]) + cmntg_pkg::LEN_W'(sq_q[1])
               + cmntg_pkg::LEN_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i]  <= {sq_q[i], {(2 * cmntg_pkg::NORM_FRAC){1'b0}}};
        acc_q[0][i]  <= '0;
        root_q[0][i] <= '0;
      end
      len_q[0]  <= len_d;
      sgn_q[0]  <= sgn1_q;
      zero_q[0] <= (len_d == '0);
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_root
    localparam int unsigned BIT = STEPS - 1 - s;
    logic [cmntg_pkg::TRY_W-1:0] trial [3];
    logic [2:0] take;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = (cmntg_pkg::TRY_W'(acc_q[s][i]) << (BIT + 1))
                 + (cmntg_pkg::TRY_W'(len_q[s]) << (2 * BIT));
        take[i]  = trial[i] <= cmntg_pkg::TRY_W'(rem_q[s][i]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[ST_SQRT0 + s]) begin
        for (int i = 0; i < 3; i++) begin
          if (take[i]) begin
            rem_q[s+1][i]  <= rem_q[s][i] - cmntg_pkg::REM_W'(trial[i]);
            acc_q[s+1][i]  <= acc_q[s][i]
                            + (cmntg_pkg::ACC_W'(len_q[s]) << BIT);
            root_q[s+1][i] <= root_q[s][i] | (cmntg_pkg::ROOT_W'(1) << BIT);
          end else begin
            rem_q[s+1][i]  <= rem_q[s][i];
            acc_q[s+1][i]  <= acc_q[s][i];
            root_q[s+1][i] <= root_q[s][i];
          end
        end
        len_q[s+1]  <= len_q[s];
        sgn_q[s+1]  <= sgn_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Apply sign; a zero-length direction normalizes to zero
  // --------------------------------------------------------------------------
  logic signed [cmntg_pkg::NV_W-1:0] nv_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[ST_NV]) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_q[STEPS]) begin
          nv_q[i] <= '0;
        end else if (sgn_q[STEPS][i]) begin
          nv_q[i] <= -$signed({1'b0, root_q[STEPS][i]});
        end else begin
          nv_q[i] <= $signed({1'b0, root_q[STEPS][i]});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row vector times matrix: nine products, then column sums plus bias 1.0
  // --------------------------------------------------------------------------
  logic signed [cmntg_pkg::PROD_W-1:0] prod_q [3][3];
  logic signed [SUM_W-1:0]             csum_q [3];
  logic signed [PK_W-1:0]              pk_q   [3];
  logic [7:0]                          pix_q  [3];
  logic signed [cmntg_pkg::COEF_W-1:0] coef   [3][3];
  logic signed [SUM_W-1:0]             bias;
  logic signed [PK_W-1:0]              pk_sh  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j] = $signed(row_q[i][16*j +: 16]);
      end
    end
    bias = SUM_W'(1) <<< TOT_FRAC;
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_PROD]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= nv_q[i] * coef[i][j];
        end
      end
    end
    if (adv[ST_SUM]) begin
      for (int j = 0; j < 3; j++) begin
        csum_q[j] <= SUM_W'(prod_q[0][j]) + SUM_W'(prod_q[1][j])
                   + SUM_W'(prod_q[2][j]) + bias;
      end
    end
    if (adv[ST_PK]) begin
      for (int j = 0; j < 3; j++) begin
        pk_q[j] <= (PK_W'(csum_q[j]) <<< 8) - PK_W'(csum_q[j]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale by 127.5 and saturate to 0..255; this is the output register
  // --------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pk_sh[j] = pk_q[j] >>> (TOT_FRAC + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      for (int j = 0; j < 3; j++) begin
        if (pk_q[j][PK_W-1] || (pk_q[j] == '0)) begin
          pix_q[j] <= 8'd0;
        end else if (pk_sh[j] > PK_W'(255)) begin
          pix_q[j] <= 8'd255;
        end else begin
          pix_q[j] <= pk_sh[j][7:0];
        end
      end
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {pix_q[2], pix_q[1], pix_q[0]};

endmodule
`default_nettype wire

>>> rtl/core/cmntg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmntg_checker
// Port-level checks of the texel generator stream behavior.
// ----------------------------------------------------------------------------
module cmntg_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [cmntg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // A free output slot lets every stage move, so a request is taken
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output slot free");

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result present right after reset");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind cube_map_normal_texel_gen cmntg_checker u_cmntg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
